// ===== src/tts_pkg.sv =====
// Shared types, codes and constants for the two-sample t statistic block.
`timescale 1ns / 1ps
package tts_pkg;

    localparam int DEF_MAX_SAMPLES = 65536;
    localparam int DEF_VALUE_WIDTH = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int DIR_W           = 2;
    localparam int STATUS_W        = 2;
    localparam int T_W             = 32;
    localparam int Q_W             = 64;   // quotient kept before the root
    localparam int FRAC_BITS       = 32;   // t^2 scale, Q32.32

    typedef enum logic [DIR_W-1:0] {
        DIR_KEEP = 2'd0,
        DIR_NEG  = 2'd1,
        DIR_ABS  = 2'd2
    } dir_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FEW      = 2'd1,
        ST_G0_EMPTY = 2'd2,
        ST_G1_EMPTY = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        OP_D1  = 4'd0,
        OP_D0  = 4'd1,
        OP_X0  = 4'd2,
        OP_SQ0 = 4'd3,
        OP_W0  = 4'd4,
        OP_X1  = 4'd5,
        OP_SQ1 = 4'd6,
        OP_W1  = 4'd7,
        OP_DD  = 4'd8,
        OP_NUM = 4'd9,
        OP_DEN = 4'd10
    } op_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_CHECK,
        B_SETUP,
        B_MUL,
        B_POST,
        B_DIVSET,
        B_DIV,
        B_SQSET,
        B_SQRT,
        B_OUT
    } bstate_t;

    typedef struct packed {
        logic pop;
        logic out_load;
    } bctl_t;

endpackage

// ===== src/tts_in_if.sv =====
// Sample channel: valid/ready with one sample, its group and the last flag.
`timescale 1ns / 1ps
interface tts_in_if
    import tts_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] sample_value;
    logic                          group_label;
    logic                          is_last;

    modport source (output valid, output sample_value, output group_label, output is_last,
                    input ready);
    modport sink   (input valid, input sample_value, input group_label, input is_last,
                    output ready);
endinterface

// ===== src/tts_out_if.sv =====
// Result channel: valid/ready with t value, status and saturation flag.
`timescale 1ns / 1ps
interface tts_out_if
    import tts_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic signed [T_W-1:0] t_value;
    logic [STATUS_W-1:0]   status;
    logic                  saturated;

    modport source (output valid, output t_value, output status, output saturated,
                    input ready);
    modport sink   (input valid, input t_value, input status, input saturated,
                    output ready);
endinterface

// ===== src/two_sample_t_statistic.sv =====
// Top level: pooled two-sample t statistic, front accumulator, queue and back unit.
//
//  channel     dir  handshake      payload
//  sample_ch   in   valid/ready    sample_value, group_label, is_last
//  result_ch   out  valid/ready    t_value, status, saturated
//  cfg         in   cfg_we         cfg_wdata (direction)
//
// Samples are taken one per cycle into the per-group accumulators.
// A last sample queues a snapshot (the queue holds two entries); the back unit
// then runs eleven shift-add multiplies, PW+32 divide steps and 32 root steps
// per result. Input stalls only while the queue is full.
// Reset clears accumulators, queue and direction; no clearing pass.
`timescale 1ns / 1ps
module two_sample_t_statistic
    import tts_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [DIR_W-1:0] cfg_wdata,
    tts_in_if.sink           sample_ch,
    tts_out_if.source        result_ch
);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int EW = 2 * (CW + VALUE_WIDTH + CW + 2 * VALUE_WIDTH + CW - 2);

    logic [DIR_W-1:0] direction_reg;
    logic [EW-1:0]    wentry, rentry;
    logic             push, pop, q_full, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_KEEP;
        end
        else if (cfg_we)
        begin
            direction_reg <= cfg_wdata;
        end
    end

    tts_front #(.MAX_SAMPLES(MAX_SAMPLES), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .q_full    (q_full),
        .push      (push),
        .entry     (wentry)
    );

    tts_fifo #(.WIDTH(EW)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wentry),
        .pop   (pop),
        .rdata (rentry),
        .full  (q_full),
        .empty (q_empty)
    );

    tts_back #(.MAX_SAMPLES(MAX_SAMPLES), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .direction (direction_reg),
        .q_empty   (q_empty),
        .entry     (rentry),
        .pop       (pop),
        .result_ch (result_ch)
    );
endmodule

// ===== src/tts_fifo.sv =====
// Short queue of finished accumulator snapshots between front and back.
`timescale 1ns / 1ps
module tts_fifo
    import tts_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;

    assign full  = cnt_reg == CNTW'(QUEUE_DEPTH);
    assign empty = cnt_reg == '0;
    assign rdata = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop)
        begin
            rp_next = (rp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end
endmodule

// ===== src/tts_front.sv =====
// Front: per-group count, sum and sum of squares; snapshot on the last sample.
`timescale 1ns / 1ps
module tts_front
    import tts_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    tts_in_if.sink         sample_ch,
    input  logic           q_full,
    output logic           push,
    output logic [2*($clog2(MAX_SAMPLES+1)+VALUE_WIDTH+$clog2(MAX_SAMPLES+1)
                   +2*VALUE_WIDTH+$clog2(MAX_SAMPLES+1)-2)-1:0] entry
);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = VALUE_WIDTH + CW;
    localparam int QW = 2 * VALUE_WIDTH + CW - 2;

    logic [CW-1:0]          n0_reg, n0_next, n1_reg, n1_next;
    logic signed [SW-1:0]   s0_reg, s0_next, s1_reg, s1_next;
    logic [QW-1:0]          q0_reg, q0_next, q1_reg, q1_next;
    logic signed [2*VALUE_WIDTH-1:0] prod;
    logic signed [SW-1:0]   v_ext;
    logic [QW-1:0]          sq;
    logic [CW:0]            tot;
    logic                   acc, add_en;

    assign sample_ch.ready = !q_full;
    assign acc   = sample_ch.valid && sample_ch.ready;
    assign push  = acc && sample_ch.is_last;
    assign v_ext = SW'(sample_ch.sample_value);
    assign prod  = sample_ch.sample_value * sample_ch.sample_value;
    assign sq    = QW'($unsigned(prod));
    assign tot   = {1'b0, n0_reg} + {1'b0, n1_reg};
    assign add_en = tot < (CW+1)'(MAX_SAMPLES);

    always_comb
    begin
        n0_next = n0_reg;
        n1_next = n1_reg;
        s0_next = s0_reg;
        s1_next = s1_reg;
        q0_next = q0_reg;
        q1_next = q1_reg;
        if (add_en)
        begin
            if (!sample_ch.group_label)
            begin
                n0_next = n0_reg + 1'b1;
                s0_next = s0_reg + v_ext;
                q0_next = q0_reg + sq;
            end
            else
            begin
                n1_next = n1_reg + 1'b1;
                s1_next = s1_reg + v_ext;
                q1_next = q1_reg + sq;
            end
        end
    end

    assign entry = {q1_next, q0_next, s1_next, s0_next, n1_next, n0_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n0_reg <= '0;
            n1_reg <= '0;
            s0_reg <= '0;
            s1_reg <= '0;
            q0_reg <= '0;
            q1_reg <= '0;
        end
        else if (acc)
        begin
            if (sample_ch.is_last)
            begin
                n0_reg <= '0;
                n1_reg <= '0;
                s0_reg <= '0;
                s1_reg <= '0;
                q0_reg <= '0;
                q1_reg <= '0;
            end
            else
            begin
                n0_reg <= n0_next;
                n1_reg <= n1_next;
                s0_reg <= s0_next;
                s1_reg <= s1_next;
                q0_reg <= q0_next;
                q1_reg <= q1_next;
            end
        end
    end
endmodule

// ===== src/tts_back.sv =====
// Back: shift-add multiplier, restoring divider and integer root for one snapshot.
`timescale 1ns / 1ps
module tts_back
    import tts_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [DIR_W-1:0]    direction,
    input  logic                q_empty,
    input  logic [2*($clog2(MAX_SAMPLES+1)+VALUE_WIDTH+$clog2(MAX_SAMPLES+1)
                   +2*VALUE_WIDTH+$clog2(MAX_SAMPLES+1)-2)-1:0] entry,
    output logic                pop,
    tts_out_if.source           result_ch
);
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int SW   = VALUE_WIDTH + CW;
    localparam int QW   = 2 * VALUE_WIDTH + CW - 2;
    localparam int DW   = SW + CW;
    localparam int PA   = 2 * DW + CW;
    localparam int PB   = QW + 3 * CW + 2;
    localparam int PW   = (PA > PB) ? PA : PB;
    localparam int NUMW = PW + FRAC_BITS;
    localparam int DCW  = $clog2(NUMW + 1);

    bstate_t state_reg, state_next;
    bctl_t   ctl;
    op_t     op_reg;

    logic [CW-1:0]        n0_reg, n1_reg, nt;
    logic signed [SW-1:0] s0_reg, s1_reg;
    logic [QW-1:0]        q0_reg, q1_reg;
    logic [SW-1:0]        m0, m1;
    logic signed [DW:0]   d_reg, pd;
    logic [DW-1:0]        dm;
    logic [PW-1:0]        x_reg, w_reg, num_reg, den_reg;
    logic [PW-1:0]        a_reg, p_reg, a_sel;
    logic [DW-1:0]        b_reg, b_sel;
    status_t              st_reg, st_calc;
    logic [NUMW-1:0]      nsh_reg;
    logic [PW-1:0]        rem_reg;
    logic [PW:0]          r2;
    logic                 ge;
    logic [Q_W-1:0]       quo_reg;
    logic                 over_reg;
    logic [DCW-1:0]       dcnt_reg;
    logic [Q_W-1:0]       sx_reg, res_reg, bit_reg, rb;
    logic [T_W-1:0]       m, mag_out;
    logic                 neg, sat;
    logic signed [T_W-1:0] t_calc;
    logic                 ov_reg;

    assign nt = n0_reg + n1_reg;
    assign m0 = s0_reg[SW-1] ? SW'(-s0_reg) : SW'(s0_reg);
    assign m1 = s1_reg[SW-1] ? SW'(-s1_reg) : SW'(s1_reg);
    assign dm = d_reg[DW] ? DW'(-d_reg) : DW'(d_reg);

    always_comb
    begin
        if (nt < CW'(3))
        begin
            st_calc = ST_FEW;
        end
        else if (n0_reg == '0)
        begin
            st_calc = ST_G0_EMPTY;
        end
        else if (n1_reg == '0)
        begin
            st_calc = ST_G1_EMPTY;
        end
        else
        begin
            st_calc = ST_OK;
        end
    end

    always_comb
    begin
        unique case (op_reg)
            OP_D1:   begin a_sel = PW'(m1);     b_sel = DW'(n0_reg);       end
            OP_D0:   begin a_sel = PW'(m0);     b_sel = DW'(n1_reg);       end
            OP_X0:   begin a_sel = PW'(q0_reg); b_sel = DW'(n0_reg);       end
            OP_SQ0:  begin a_sel = PW'(m0);     b_sel = DW'(m0);           end
            OP_W0:   begin a_sel = x_reg;       b_sel = DW'(n1_reg);       end
            OP_X1:   begin a_sel = PW'(q1_reg); b_sel = DW'(n1_reg);       end
            OP_SQ1:  begin a_sel = PW'(m1);     b_sel = DW'(m1);           end
            OP_W1:   begin a_sel = x_reg;       b_sel = DW'(n0_reg);       end
            OP_DD:   begin a_sel = PW'(dm);     b_sel = dm;                end
            OP_NUM:  begin a_sel = x_reg;       b_sel = DW'(nt - CW'(2));  end
            OP_DEN:  begin a_sel = w_reg;       b_sel = DW'(nt);           end
            default: begin a_sel = '0;          b_sel = '0;                end
        endcase
    end

    assign pd = (DW+1)'(p_reg);
    assign r2 = {rem_reg, nsh_reg[NUMW-1]};
    assign ge = r2 >= {1'b0, den_reg};
    assign rb = res_reg + bit_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:   if (!q_empty) state_next = B_CHECK;
            B_CHECK:  state_next = (st_calc == ST_OK) ? B_SETUP : B_OUT;
            B_SETUP:  state_next = B_MUL;
            B_MUL:    if (b_reg == '0) state_next = B_POST;
            B_POST:   state_next = (op_reg == OP_DEN) ? B_DIVSET : B_SETUP;
            B_DIVSET: state_next = (w_reg == '0) ? B_OUT : B_DIV;
            B_DIV:    if (dcnt_reg == '0) state_next = B_SQSET;
            B_SQSET:  state_next = B_SQRT;
            B_SQRT:   if (bit_reg == '0) state_next = B_OUT;
            B_OUT:    if (!ov_reg || result_ch.ready) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.pop      = (state_reg == B_IDLE) && !q_empty;
        ctl.out_load = (state_reg == B_OUT) && (!ov_reg || result_ch.ready);
    end

    assign pop = ctl.pop;

    always_comb
    begin
        if (w_reg == '0)
        begin
            m = (dm != '0) ? '1 : '0;
        end
        else
        begin
            m = res_reg[T_W-1:0];
        end
        unique case (dir_t'(direction))
            DIR_NEG: neg = !d_reg[DW];
            DIR_ABS: neg = 1'b0;
            default: neg = d_reg[DW];
        endcase
        if (!neg)
        begin
            sat     = m[T_W-1];
            mag_out = sat ? {1'b0, {(T_W-1){1'b1}}} : m;
            t_calc  = $signed(mag_out);
        end
        else
        begin
            sat     = m[T_W-1] && (|m[T_W-2:0]);
            mag_out = sat ? {1'b1, {(T_W-1){1'b0}}} : m;
            t_calc  = $signed(-mag_out);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pop)
        begin
            {q1_reg, q0_reg, s1_reg, s0_reg, n1_reg, n0_reg} <= entry;
        end
        unique case (state_reg)
            B_CHECK:
            begin
                st_reg <= st_calc;
                op_reg <= OP_D1;
                w_reg  <= '0;
                d_reg  <= '0;
            end
            B_SETUP:
            begin
                a_reg <= a_sel;
                b_reg <= b_sel;
                p_reg <= '0;
            end
            B_MUL:
            begin
                if (b_reg != '0)
                begin
                    if (b_reg[0])
                    begin
                        p_reg <= p_reg + a_reg;
                    end
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg >> 1;
                end
            end
            B_POST:
            begin
                unique case (op_reg)
                    OP_D1:   d_reg <= s1_reg[SW-1] ? -pd : pd;
                    OP_D0:   d_reg <= s0_reg[SW-1] ? d_reg + pd : d_reg - pd;
                    OP_X0:   x_reg <= p_reg;
                    OP_SQ0:  x_reg <= x_reg - p_reg;
                    OP_W0:   w_reg <= p_reg;
                    OP_X1:   x_reg <= p_reg;
                    OP_SQ1:  x_reg <= x_reg - p_reg;
                    OP_W1:   w_reg <= w_reg + p_reg;
                    OP_DD:   x_reg <= p_reg;
                    OP_NUM:  num_reg <= p_reg;
                    OP_DEN:  den_reg <= p_reg;
                    default: x_reg <= x_reg;
                endcase
                if (op_reg != OP_DEN)
                begin
                    op_reg <= op_t'(op_reg + 1'b1);
                end
            end
            B_DIVSET:
            begin
                nsh_reg  <= {num_reg, {FRAC_BITS{1'b0}}};
                rem_reg  <= '0;
                quo_reg  <= '0;
                over_reg <= 1'b0;
                dcnt_reg <= DCW'(NUMW);
                res_reg  <= '0;
            end
            B_DIV:
            begin
                if (dcnt_reg != '0)
                begin
                    nsh_reg  <= nsh_reg << 1;
                    rem_reg  <= ge ? PW'(r2 - {1'b0, den_reg}) : PW'(r2);
                    quo_reg  <= {quo_reg[Q_W-2:0], ge};
                    over_reg <= over_reg | quo_reg[Q_W-1];
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
            end
            B_SQSET:
            begin
                sx_reg  <= over_reg ? '1 : quo_reg;
                res_reg <= '0;
                bit_reg <= {2'b01, {(Q_W-2){1'b0}}};
            end
            B_SQRT:
            begin
                if (bit_reg != '0)
                begin
                    if (sx_reg >= rb)
                    begin
                        sx_reg  <= sx_reg - rb;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            default:
            begin
            end
        endcase
        if (ctl.out_load)
        begin
            result_ch.status <= st_reg;
            if (st_reg != ST_OK)
            begin
                result_ch.t_value   <= '0;
                result_ch.saturated <= 1'b0;
            end
            else
            begin
                result_ch.t_value   <= t_calc;
                result_ch.saturated <= sat;
            end
        end
    end

    assign result_ch.valid = ov_reg;
endmodule

// ===== verif/tts_stim_if.sv =====
// Configuration channel driven by the testbench: write enable and direction data.
`timescale 1ns / 1ps
interface tts_cfg_if;
    logic       we;
    logic [1:0] wdata;

    modport source (output we, output wdata);
    modport sink   (input we, input wdata);
endinterface

// ===== verif/tb_two_sample_t_statistic.sv =====
// Testbench for two_sample_t_statistic: directed table, random variables, scoreboard.
`timescale 1ns / 1ps
module tb_two_sample_t_statistic;
    import tts_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int RANDOM_ITEMS   = 2000;

    typedef struct {
        logic [31:0] t_value;
        status_t     status;
        logic        saturated;
    } t_result_t;

    typedef struct {
        shortint     value;
        logic        grp;
        logic        last;
        logic        typed;
        logic [31:0] t_value;
        status_t     status;
        logic        saturated;
    } stim_row_t;

    logic clk;
    logic rst_n;
    tts_cfg_if cfg();
    tts_in_if #(.VALUE_WIDTH(DEF_VALUE_WIDTH)) sample_ch();
    tts_out_if result_ch();

    two_sample_t_statistic DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.we),
        .cfg_wdata (cfg.wdata),
        .sample_ch (sample_ch.sink),
        .result_ch (result_ch.source)
    );

    // predictor state
    logic [1:0]   direction;
    int unsigned  cnt0, cnt1;
    longint       sum0, sum1;
    logic [255:0] sq0, sq1;

    t_result_t    pending_results[$];
    int           errors;
    int           idle_cycles;
    bit           no_idle;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] isqrt64(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [255:0] pooled_term(int unsigned n, longint s, logic [255:0] q,
                                                 int unsigned other);
        logic [255:0] r, s2, mag;
        mag = (s < 0) ? 256'(-s) : 256'(s);
        s2 = mag * mag;
        r = q * 256'(n);
        r = r - s2;
        return r * 256'(other);
    endfunction

    function automatic t_result_t t_statistic();
        t_result_t    res;
        int unsigned  nt;
        longint       d;
        logic [63:0]  dm, m;
        logic [255:0] w, num, den, quo;
        logic         neg;
        res.t_value = 0;
        res.saturated = 0;
        nt = cnt0 + cnt1;
        if (nt < 3) res.status = ST_FEW;
        else if (cnt0 == 0) res.status = ST_G0_EMPTY;
        else if (cnt1 == 0) res.status = ST_G1_EMPTY;
        else
        begin
            res.status = ST_OK;
            d = sum1 * longint'(cnt0) - sum0 * longint'(cnt1);
            neg = d < 0;
            dm = neg ? 64'(-d) : 64'(d);
            w = pooled_term(cnt0, sum0, sq0, cnt1) + pooled_term(cnt1, sum1, sq1, cnt0);
            if (w == 0)
                m = (dm != 0) ? 64'h1_0000_0000 : 64'd0;
            else
            begin
                num = 256'(dm) * 256'(dm);
                num = num * 256'(nt - 2);
                num = num << 32;
                den = w * 256'(nt);
                quo = num / den;
                m = (quo[255:64] != 0) ? 64'h1_0000_0000 : isqrt64(quo[63:0]);
            end
            if (direction == DIR_NEG) neg = ~neg;
            else if (direction == DIR_ABS) neg = 1'b0;
            if (!neg)
            begin
                if (m > 64'h7FFF_FFFF) begin m = 64'h7FFF_FFFF; res.saturated = 1; end
                res.t_value = m[31:0];
            end
            else
            begin
                if (m > 64'h8000_0000) begin m = 64'h8000_0000; res.saturated = 1; end
                res.t_value = 32'(-m);
            end
        end
        return res;
    endfunction

    function automatic void clear_sums();
        cnt0 = 0; cnt1 = 0; sum0 = 0; sum1 = 0; sq0 = 0; sq1 = 0;
    endfunction

    // returns 1 when the transfer closes a variable
    function automatic bit absorb(shortint v, logic grp, logic last, output t_result_t res);
        logic [255:0] sq;
        sq = 256'(longint'(v) * longint'(v));
        if (cnt0 + cnt1 < DEF_MAX_SAMPLES)
        begin
            if (!grp) begin cnt0++; sum0 += v; sq0 += sq; end
            else      begin cnt1++; sum1 += v; sq1 += sq; end
        end
        if (!last) return 0;
        res = t_statistic();
        clear_sums();
        return 1;
    endfunction

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_sample(shortint v, logic grp, logic last, output t_result_t res,
                               output bit closes);
        int g;
        g = gap_len();
        @(negedge clk);
        if (g > 0)
        begin
            sample_ch.valid = 1'b0;
            repeat (g) @(negedge clk);
        end
        sample_ch.sample_value = v;
        sample_ch.group_label  = grp;
        sample_ch.is_last      = last;
        sample_ch.valid        = 1'b1;
        do @(posedge clk); while (!sample_ch.ready);
        closes = absorb(v, grp, last, res);
    endtask

    task automatic send_checked(shortint v, logic grp, logic last);
        t_result_t res;
        bit        closes;
        send_sample(v, grp, last, res, closes);
        if (closes) pending_results.push_back(res);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_direction(logic [1:0] d);
        wait_drained();
        @(negedge clk);
        cfg.we    = 1'b1;
        cfg.wdata = d;
        @(negedge clk);
        cfg.we = 1'b0;
        direction = d;
    endtask

    function automatic shortint pick_value(int kind, shortint base);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            0: return (r < 8) ? -16'sd32768 : (r < 16) ? 16'sd32767 : shortint'($urandom);
            1: return base + shortint'($urandom_range(0, 6)) - 16'sd3;
            default: return base;
        endcase
    endfunction

    task automatic send_variable(ref int sent);
        int      len, kind, r, bias;
        shortint base;
        logic    grp;
        r = $urandom_range(0, 99);
        len = (r < 10) ? $urandom_range(1, 2) : (r < 15) ? $urandom_range(3, 60)
                                                        : $urandom_range(3, 24);
        kind = $urandom_range(0, 2);
        base = shortint'($urandom);
        bias = $urandom_range(0, 99);
        for (int i = 0; i < len; i++)
        begin
            if (bias < 8) grp = 1'b0;
            else if (bias < 16) grp = 1'b1;
            else grp = $urandom_range(0, 1);
            if (kind == 2 && grp) base = base ^ shortint'(bias[0]);
            send_checked(pick_value(kind, base), grp, i == len - 1);
            sent++;
        end
    endtask

    stim_row_t directed[] = '{
        '{16'sd100,    1'b0, 1'b1, 1'b1, 32'h0,         ST_FEW,      1'b0},
        '{16'sd1,      1'b1, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd2,      1'b1, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd3,      1'b1, 1'b1, 1'b1, 32'h0,         ST_G0_EMPTY, 1'b0},
        '{-16'sd4,     1'b0, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd5,      1'b0, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd6,      1'b0, 1'b1, 1'b1, 32'h0,         ST_G1_EMPTY, 1'b0},
        '{16'sd5,      1'b0, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd5,      1'b0, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd7,      1'b1, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd7,      1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF, ST_OK,       1'b1},
        '{16'sd9,      1'b1, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd9,      1'b0, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd9,      1'b0, 1'b1, 1'b1, 32'h0,         ST_OK,       1'b0},
        '{16'sd3,      1'b0, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd3,      1'b1, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd3,      1'b1, 1'b1, 1'b1, 32'h0,         ST_OK,       1'b0},
        '{-16'sd32768, 1'b0, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd32767,  1'b1, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{-16'sd32767, 1'b0, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd32766,  1'b1, 1'b1, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd10,     1'b0, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{-16'sd20,    1'b1, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{16'sd14,     1'b0, 1'b0, 1'b0, 32'h0,         ST_OK,       1'b0},
        '{-16'sd1,     1'b1, 1'b1, 1'b0, 32'h0,         ST_OK,       1'b0}
    };

    // result side: random back-pressure
    initial
    begin
        int r;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            r = $urandom_range(0, 99);
            if (no_idle || r < 70)
                result_ch.ready = 1'b1;
            else
            begin
                result_ch.ready = 1'b0;
                repeat ((r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 80)) @(negedge clk);
                result_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        t_result_t exp_res;
        if (result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result t=%h status=%0d sat=%0d", $time,
                         result_ch.t_value, result_ch.status, result_ch.saturated);
                errors++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (result_ch.t_value !== exp_res.t_value)
                begin
                    $display("%0t: t_value expected %h actual %h", $time,
                             exp_res.t_value, result_ch.t_value);
                    errors++;
                end
                if (result_ch.status !== exp_res.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_res.status, result_ch.status);
                    errors++;
                end
                if (result_ch.saturated !== exp_res.saturated)
                begin
                    $display("%0t: saturated expected %0d actual %0d", $time,
                             exp_res.saturated, result_ch.saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        t_result_t   res;
        bit          closes;
        int          sent;
        logic [1:0]  dir_plan[] = '{DIR_NEG, DIR_ABS, 2'd3, DIR_KEEP, DIR_NEG};
        errors = 0;
        idle_cycles = 0;
        no_idle = 0;
        sent = 0;
        direction = DIR_KEEP;
        clear_sums();
        rst_n = 1'b0;
        cfg.we = 1'b0;
        cfg.wdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.sample_value = '0;
        sample_ch.group_label = 1'b0;
        sample_ch.is_last = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            send_sample(directed[i].value, directed[i].grp, directed[i].last, res, closes);
            if (closes)
            begin
                if (directed[i].typed)
                begin
                    res.t_value   = directed[i].t_value;
                    res.status    = directed[i].status;
                    res.saturated = directed[i].saturated;
                end
                pending_results.push_back(res);
            end
        end

        for (int ph = 0; sent < RANDOM_ITEMS; ph++)
        begin
            set_direction(ph < dir_plan.size() ? dir_plan[ph] : 2'($urandom_range(0, 3)));
            no_idle = (ph % 3 == 2);
            while (sent < (ph + 1) * (RANDOM_ITEMS / 8)) send_variable(sent);
        end
        no_idle = 0;

        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== two_sample_t_statistic.f =====
src/tts_pkg.sv
src/tts_in_if.sv
src/tts_out_if.sv
src/tts_fifo.sv
src/tts_front.sv
src/tts_back.sv
src/two_sample_t_statistic.sv
verif/tts_stim_if.sv
verif/tb_two_sample_t_statistic.sv
